// File: rtl/susi_pkg.sv
// Package for the sorted unique set insert block: field widths, parameter
// defaults, operation and status codes, controller states and the cell command struct.
// No dependencies.
package susi_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int KEY_BITS_DEF = 16;

	localparam int KEY_W    = 16;
	localparam int IDX_W    = 7;
	localparam int STATUS_W = 3;
	localparam int TOTAL_W  = 8;

	// Operation codes carried on the op field.
	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_READ_OK   = 3'd3,
		ST_BAD_INDEX = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DECIDE
	} state_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic eval;
		logic insert;
	} cell_cmd_t;

	// Compare results registered inside each cell.
	typedef struct packed {
		logic hit;
		logic above;
		logic sel;
	} cell_flag_t;

endpackage

// File: rtl/susi_cell.sv
// One storage cell of the sorted chain: an entry, its valid bit and its
// registered compare results. Depends on susi_pkg.
module susi_cell import susi_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int INDEX    = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_cmd_t           cmd,
	input  logic [KEY_BITS-1:0] key,
	input  logic [IDX_W-1:0]    read_index,
	input  logic [KEY_BITS-1:0] prev_entry,
	input  logic                prev_valid,
	input  logic                prev_above,
	output logic [KEY_BITS-1:0] entry,
	output logic                valid,
	output cell_flag_t          flag
);

	logic [KEY_BITS-1:0] entry_q;
	logic                valid_q;
	cell_flag_t          flag_q;

	// Entries never hold state that reset must clear; only valid bits do.
	always_ff @(posedge clk) begin
		if (cmd.insert && flag_q.above) begin
			entry_q <= prev_above ? prev_entry : key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flag_q  <= '0;
		end else begin
			if (cmd.insert) begin
				valid_q <= valid_q | prev_valid;
			end
			if (cmd.eval) begin
				flag_q.hit   <= valid_q && (entry_q == key);
				flag_q.above <= !valid_q || (entry_q > key);
				flag_q.sel   <= valid_q && (32'(read_index) == 32'(INDEX));
			end
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign flag  = flag_q;

endmodule

// File: rtl/susi_gather.sv
// Collects the registered cell flags: duplicate detection and the selected
// entry for a read. Depends on susi_pkg.
module susi_gather import susi_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic [CAPACITY-1:0]               hit,
	input  logic [CAPACITY-1:0]               sel,
	input  logic [CAPACITY-1:0][KEY_BITS-1:0] entries,
	output logic                              found,
	output logic                              read_hit,
	output logic [KEY_BITS-1:0]               read_value
);

	// At most one cell is selected, so an AND-OR picks its entry.
	always_comb begin
		read_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			read_value = read_value | (entries[i] & {KEY_BITS{sel[i]}});
		end
	end

	assign found    = |hit;
	assign read_hit = |sel;

endmodule

// File: rtl/sorted_unique_set_insert_top.sv
// Top level of the sorted unique set insert block: item registers, controller,
// the chain of storage cells and the result register.
// Depends on susi_pkg, susi_cell and susi_gather.
//
//  Channel | Direction | tdata (low bit first)             | tuser
//  --------+-----------+-----------------------------------+------------------
//  s_*     | in        | key_value[15:0], read_index[22:16] | op (0 offer, 1 read)
//  m_*     | out       | entry_value[15:0], entry_total[23:16] | status[2:0]
//
// Every item passes through the transfer that captures it, the evaluation
// state in which every cell compares its entry with the key and index in
// parallel, and the decision state that gathers those flags, decides the status and,
// for an insert, shifts the larger entries up one cell in a single step.
// A new item is taken only while the controller is idle. A finished result
// sits in the output register, so the next item is captured and compared
// while it waits; the decision stage holds when the register is still full.
// Reset clears the entry count and every valid bit at once; no clearing pass.
module sorted_unique_set_insert_top import susi_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // key_value[15:0], read_index[22:16], zero pad [23]
	input  logic        s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // entry_value[15:0], entry_total[23:16]
	output logic [2:0]  m_tuser   // status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	// Captured item.
	logic                op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0]    idx_q;

	logic [CNT_W-1:0] count_q;

	// Result register.
	logic                out_valid_q;
	status_t             status_q;
	logic [KEY_W-1:0]    value_q;
	logic [TOTAL_W-1:0]  total_q;

	cell_cmd_t cmd;
	logic      out_free;
	logic      decide;
	logic      full;
	status_t   status_d;
	logic [KEY_W-1:0] value_d;
	logic [CNT_W-1:0] count_d;

	logic [CAPACITY-1:0][KEY_BITS-1:0] entries;
	logic [CAPACITY-1:0]               valids;
	cell_flag_t [CAPACITY-1:0]         flags;
	logic [CAPACITY-1:0]               hits;
	logic [CAPACITY-1:0]               sels;
	logic [CAPACITY-1:0]               aboves;

	logic                found;
	logic                read_hit;
	logic [KEY_BITS-1:0] read_value;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign decide   = (state_q == S_DECIDE) && out_free;
	assign full     = (count_q == CNT_W'(CAPACITY));

	// The item is captured at its transfer; the key is cut or widened to the
	// stored key width here.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			key_q <= KEY_BITS'(s_tdata[KEY_W-1:0]);
			idx_q <= s_tdata[KEY_W +: IDX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Controller: next state, cell commands and the status decision. A key
	// already present is a duplicate even when the table is full.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		status_d   = ST_INSERTED;
		value_d    = '0;
		count_d    = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				priority if (op_q == OP_READ) begin
					if (read_hit) begin
						status_d = ST_READ_OK;
						value_d  = KEY_W'(read_value);
					end else begin
						status_d = ST_BAD_INDEX;
					end
				end else if (found) begin
					status_d = ST_DUPLICATE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_INSERTED;
					count_d  = count_q + CNT_W'(1);
					cmd.insert = decide;
				end
				if (decide) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (decide) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			status_q <= status_d;
			value_q  <= value_d;
			total_q  <= TOTAL_W'(count_d);
		end
	end

	// Chain of cells; cell 0 sees a valid, non-larger neighbour below it so
	// that it takes the key itself when an insert reaches it.
	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [KEY_BITS-1:0] prev_entry;
			logic                prev_valid;
			logic                prev_above;
			if (g == 0) begin : g_head
				assign prev_entry = '0;
				assign prev_valid = 1'b1;
				assign prev_above = 1'b0;
			end else begin : g_link
				assign prev_entry = entries[g-1];
				assign prev_valid = valids[g-1];
				assign prev_above = aboves[g-1];
			end
			susi_cell #(
				.KEY_BITS (KEY_BITS),
				.INDEX    (g)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.key        (key_q),
				.read_index (idx_q),
				.prev_entry (prev_entry),
				.prev_valid (prev_valid),
				.prev_above (prev_above),
				.entry      (entries[g]),
				.valid      (valids[g]),
				.flag       (flags[g])
			);
			assign hits[g]   = flags[g].hit;
			assign sels[g]   = flags[g].sel;
			assign aboves[g] = flags[g].above;
		end
	endgenerate

	susi_gather #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_gather (
		.hit        (hits),
		.sel        (sels),
		.entries    (entries),
		.found      (found),
		.read_hit   (read_hit),
		.read_value (read_value)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {total_q, value_q};
	assign m_tuser  = status_q;

endmodule

// File: rtl/susi_checker.sv
// Port-level checker for the sorted unique set insert block, bound to the top
// level. Depends on susi_pkg.
module susi_checker import susi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// A held result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only the defined status codes leave the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ST_BAD_INDEX)
		else $error("undefined status code");

	// Only a successful read carries an entry value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_READ_OK |-> m_tdata[15:0] == 16'd0)
		else $error("entry value set on a result that is not a read");

	// One item at a time: the input side closes after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in progress");

	// A result cannot appear in the cycle right after an input transfer.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind sorted_unique_set_insert_top susi_checker u_susi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/sorted_unique_set_insert_top_test.sv
// Self-checking testbench for sorted_unique_set_insert_top: directed table, then random offers
// and reads checked against a predictor of the sorted key set.
// Depends on susi_pkg and the RTL of sorted_unique_set_insert_top.
module sorted_unique_set_insert_top_test;
	import susi_pkg::*;

	localparam int SET_DEPTH     = CAPACITY_DEF;
	localparam int RANDOM_ITEMS  = 1230;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int HOLD_OFF_LEN  = 250;

	// One result as it leaves the block on the master side.
	typedef struct packed {
		status_t               status;
		logic [KEY_W-1:0]      value;
		logic [TOTAL_W-1:0]    total;
	} set_result_t;

	// A row of the directed plan. Where is_typed is set, the expectation is written
	// out in the row; otherwise it comes from the predictor.
	typedef struct {
		logic                  op;
		logic [KEY_W-1:0]      key;
		logic [IDX_W-1:0]      idx;
		bit                    is_typed;
		status_t               status;
		logic [KEY_W-1:0]      value;
		logic [TOTAL_W-1:0]    total;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [23:0]        s_tdata;   // key_value[15:0], read_index[22:16], zero pad [23]
	logic               s_tuser;   // op
	logic               m_tvalid;
	logic               m_tready;
	logic [23:0]        m_tdata;   // entry_value[15:0], entry_total[23:16]
	logic [2:0]         m_tuser;   // status

	sorted_unique_set_insert_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Predictor state: the keys held in ascending order and how many there are.
	logic [KEY_W-1:0]   held_keys [SET_DEPTH];
	int unsigned        held_count;

	// Expectations in transfer order, oldest at the front.
	set_result_t        pending_results [$];

	int                 error_count;
	int                 items_sent;
	int                 status_seen [8];
	int                 offer_gap_pct;
	int                 accept_stall_pct;
	int                 hold_off_left;

	// The directed plan. The first rows start from an empty set, so their results can
	// be written down directly; the rows after that lean on the predictor.
	plan_row_t directed_plan [23] = '{
		// Reads of an empty set are all bad, whatever the index.
		'{OP_READ,  16'hFFFF, 7'd0,   1, ST_BAD_INDEX, 16'h0000, 8'd0},
		'{OP_READ,  16'h0000, 7'd127, 1, ST_BAD_INDEX, 16'h0000, 8'd0},
		// Both key extremes go in, then come back as duplicates.
		'{OP_OFFER, 16'h0000, 7'd127, 1, ST_INSERTED,  16'h0000, 8'd1},
		'{OP_OFFER, 16'hFFFF, 7'd0,   1, ST_INSERTED,  16'h0000, 8'd2},
		'{OP_OFFER, 16'h0000, 7'h55,  1, ST_DUPLICATE, 16'h0000, 8'd2},
		'{OP_OFFER, 16'hFFFF, 7'h2A,  1, ST_DUPLICATE, 16'h0000, 8'd2},
		'{OP_READ,  16'hAAAA, 7'd0,   1, ST_READ_OK,   16'h0000, 8'd2},
		'{OP_READ,  16'h5555, 7'd1,   1, ST_READ_OK,   16'hFFFF, 8'd2},
		// One past the last entry is a bad index.
		'{OP_READ,  16'h0000, 7'd2,   1, ST_BAD_INDEX, 16'h0000, 8'd2},
		'{OP_OFFER, 16'h8000, 7'd0,   1, ST_INSERTED,  16'h0000, 8'd3},
		// Keys landing between existing entries, so the larger ones have to move up; the last repeats one.
		'{OP_OFFER, 16'h7FFF, 7'd0,   0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_OFFER, 16'h0001, 7'h7F,  0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_OFFER, 16'hFFFE, 7'h40,  0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_OFFER, 16'h8001, 7'h01,  0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_OFFER, 16'h7FFF, 7'h3F,  0, ST_INSERTED,  16'h0000, 8'd0},
		// Walk the whole set in order and step one past its end.
		'{OP_READ,  16'h1234, 7'd0,   0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_READ,  16'h0000, 7'd1,   0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_READ,  16'hFFFF, 7'd2,   0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_READ,  16'h00FF, 7'd3,   0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_READ,  16'hFF00, 7'd4,   0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_READ,  16'h0F0F, 7'd5,   0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_READ,  16'hF0F0, 7'd6,   0, ST_INSERTED,  16'h0000, 8'd0},
		'{OP_READ,  16'h0000, 7'd7,   0, ST_INSERTED,  16'h0000, 8'd0}
	};

	// Clock with a period of two units.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Works out the result of one item and updates the predicted set. An offer counts
	// the held keys below its key and looks for an equal one; a present key is a
	// duplicate even when the set is full, an absent one is refused once it is full.
	function automatic set_result_t predict_item(input logic op, input logic [KEY_W-1:0] key,
			input logic [IDX_W-1:0] idx);
		set_result_t result;
		int unsigned slot;
		bit          present;
		result.value = '0;
		if (op == OP_READ) begin
			if (idx < held_count) begin
				result.status = ST_READ_OK;
				result.value  = held_keys[idx];
			end else begin
				result.status = ST_BAD_INDEX;
			end
		end else begin
			slot    = 0;
			present = 1'b0;
			for (int i = 0; i < held_count; i++) begin
				if (held_keys[i] == key)
					present = 1'b1;
				else if (held_keys[i] < key)
					slot++;
			end
			if (present) begin
				result.status = ST_DUPLICATE;
			end else if (held_count >= SET_DEPTH) begin
				result.status = ST_FULL;
			end else begin
				for (int i = held_count; i > slot; i--)
					held_keys[i] = held_keys[i-1];
				held_keys[slot] = key;
				held_count++;
				result.status = ST_INSERTED;
			end
		end
		result.total = TOTAL_W'(held_count);
		return result;
	endfunction

	// Gap length for either side: mostly short, sometimes longer, rarely long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(1, 3);
		else if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one item from a falling edge, waits for its transfer, records the expectation
	// and returns at the next falling edge with tvalid still high. The caller lowers
	// tvalid only when a gap follows, so tvalid is never dropped and raised in one step.
	task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
			input logic [IDX_W-1:0] idx, input bit is_typed, input set_result_t typed_result);
		set_result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, idx, key};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_item(op, key, idx);
		pending_results.push_back(is_typed ? typed_result : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Inserts a sender gap after a transfer, at the rate set for the current stretch.
	task automatic maybe_pause_sender();
		if ($urandom_range(0, 99) < offer_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat (pick_gap()) @(negedge clk);
		end
	endtask

	// Builds one random item. Offers favour keys already held and their neighbours, so
	// duplicates and inserts between close keys are common; reads mostly hit the valid
	// range or its first index past the end. Unused fields carry random junk.
	task automatic send_random_item();
		logic             op;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
		int               roll;
		op   = ($urandom_range(0, 99) < 55) ? OP_OFFER : OP_READ;
		key  = KEY_W'($urandom);
		idx  = IDX_W'($urandom);
		roll = $urandom_range(0, 99);
		if (op == OP_OFFER && held_count != 0) begin
			if (roll < 25)
				key = held_keys[$urandom_range(0, held_count - 1)];
			else if (roll < 35)
				key = held_keys[$urandom_range(0, held_count - 1)] + KEY_W'(1);
			else if (roll < 40)
				key = roll[0] ? '1 : '0;
		end else if (op == OP_READ) begin
			if (roll < 60 && held_count != 0)
				idx = IDX_W'($urandom_range(0, held_count - 1));
			else if (roll < 75)
				idx = IDX_W'(held_count);
		end
		send_item(op, key, idx, 1'b0, '0);
	endtask

	// Receiver: drives m_tready at each falling edge. A hold-off requested by the
	// stimulus process takes precedence and is counted down here, cycle by cycle.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				m_tready <= 1'b0;
				hold_off_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < accept_stall_pct) begin
				m_tready   <= 1'b0;
				stall_left = pick_gap() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result checker: every master-side transfer is matched against the oldest expectation.
	always @(posedge clk) begin
		set_result_t expected;
		if (arst_n && m_tvalid && m_tready) begin
			status_seen[m_tuser]++;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: status %0d value %h total %0d",
					m_tuser, m_tdata[15:0], m_tdata[23:16]);
				error_count++;
			end else begin
				expected = pending_results.pop_front();
				if (m_tuser !== expected.status) begin
					$error("status: expected %0d, got %0d", expected.status, m_tuser);
					error_count++;
				end
				if (m_tdata[15:0] !== expected.value) begin
					$error("entry_value: expected %h, got %h", expected.value, m_tdata[15:0]);
					error_count++;
				end
				if (m_tdata[23:16] !== expected.total) begin
					$error("entry_total: expected %0d, got %0d", expected.total, m_tdata[23:16]);
					error_count++;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("sorted_unique_set_insert_top_test: done, errors");
		$finish;
	end

	// Main stimulus.
	initial begin
		set_result_t typed_result;
		int          waited;
		arst_n           = 1'b0;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		s_tuser          = OP_OFFER;
		error_count      = 0;
		items_sent       = 0;
		held_count       = 0;
		hold_off_left    = 0;
		offer_gap_pct    = 0;
		accept_stall_pct = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with light idling on both sides.
		offer_gap_pct    = 20;
		accept_stall_pct = 20;
		foreach (directed_plan[i]) begin
			typed_result.status = directed_plan[i].status;
			typed_result.value  = directed_plan[i].value;
			typed_result.total  = directed_plan[i].total;
			send_item(directed_plan[i].op, directed_plan[i].key, directed_plan[i].idx,
				directed_plan[i].is_typed, typed_result);
			maybe_pause_sender();
		end

		// Random part. The idling rates change every 150 items, so some stretches run
		// back to back and others are gappy on one side or both.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						offer_gap_pct    = 0;
						accept_stall_pct = 0;
					end
					1: begin
						offer_gap_pct    = 40;
						accept_stall_pct = 0;
					end
					2: begin
						offer_gap_pct    = 0;
						accept_stall_pct = 40;
					end
					default: begin
						offer_gap_pct    = 15;
						accept_stall_pct = 15;
					end
				endcase
			end
			// Back pressure: the receiver stops for a long stretch while the sender keeps
			// offering without gaps, so the result register fills and s_tready falls.
			if (n == 300) begin
				offer_gap_pct = 0;
				hold_off_left = HOLD_OFF_LEN;
			end
			// The sender goes quiet until every outstanding result has come back.
			if (n == 700) begin
				s_tvalid <= 1'b0;
				do
					@(negedge clk);
				while (pending_results.size() != 0);
			end
			send_random_item();
			maybe_pause_sender();
		end
		s_tvalid <= 1'b0;

		// Drain with a bound, then let the clock run on so that the pipeline can show any
		// result that should not be there.
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			error_count++;
		end

		$display("Sent %0d items; set ended with %0d of %0d keys.",
			items_sent, held_count, SET_DEPTH);
		$display("Results: %0d inserted, %0d duplicate, %0d full, %0d read, %0d bad index.",
			status_seen[ST_INSERTED], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
			status_seen[ST_READ_OK], status_seen[ST_BAD_INDEX]);
		if (error_count == 0)
			$display("sorted_unique_set_insert_top_test: done, clean");
		else
			$display("sorted_unique_set_insert_top_test: done, errors");
		$finish;
	end

endmodule

// File: sorted_unique_set_insert_top.f
rtl/susi_pkg.sv
rtl/susi_cell.sv
rtl/susi_gather.sv
rtl/sorted_unique_set_insert_top.sv
rtl/susi_checker.sv
tb/sorted_unique_set_insert_top_test.sv
